/* hdl/itda_pkg.sv */
// ----------------------------------------------------------------------------
// itda_pkg
// shared types and constants for the integer to decimal ascii converter
// ----------------------------------------------------------------------------
package itda_pkg;

    localparam int C_VALUE_WIDTH = 32;

    localparam logic [7:0] C_ASCII_ZERO  = 8'd48;
    localparam logic [7:0] C_ASCII_MINUS = 8'd45;

    // bcd digits at or above this value get the double-dabble correction
    localparam logic [3:0] C_BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] C_BCD_ADJ_ADD = 4'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } t_state;

    // commands from the sequencer to the bcd shift register
    typedef struct packed {
        logic start;
        logic shift;
    } t_bcd_cmd;

endpackage

/* hdl/itda_in_if.sv */
// ----------------------------------------------------------------------------
// itda_in_if
// input channel: one signed integer per transaction
// ----------------------------------------------------------------------------
interface itda_in_if #(
    parameter int VALUE_WIDTH = itda_pkg::C_VALUE_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

/* hdl/itda_out_if.sv */
// ----------------------------------------------------------------------------
// itda_out_if
// output channel: one ascii character per transaction
// ----------------------------------------------------------------------------
interface itda_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

/* hdl/int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// signed integer to decimal ascii text, most significant character first
//
//   channel     dir  payload                  meaning
//   i_value_ch  in   value[VALUE_WIDTH-1:0]   signed integer, two's complement
//   o_char_ch   out  char_code[7:0], last     '-' or '0'..'9', last of the run
//
// the magnitude goes through the bcd shift register one bit per cycle, then
// every digit position is walked once, leading zeros without a transaction.
// reset returns the sequencer to idle; a stall on o_char_ch just holds the
// current character, and a new value is taken only once the run is done.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = itda_pkg::C_VALUE_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itda_in_if.sink     i_value_ch,
    itda_out_if.source  o_char_ch
);
    import itda_pkg::*;

    // digits in 2^(VALUE_WIDTH-1); 1233/4096 approximates log10(2)
    localparam int DIGIT_COUNT = ((VALUE_WIDTH - 1) * 1233) / 4096 + 1;
    localparam int LEFT_W      = $clog2(DIGIT_COUNT + 1);

    t_state                 r_state, n_state;
    logic [LEFT_W-1:0]      r_left, n_left;
    logic                   r_neg, n_neg;
    t_bcd_cmd               w_cmd;
    logic [VALUE_WIDTH-1:0] w_raw;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic                   w_done;
    logic [3:0]             w_top;

    // unsigned magnitude, exact for the most negative value too
    assign w_raw = VALUE_WIDTH'(i_value_ch.value);
    assign w_mag = w_raw[VALUE_WIDTH-1] ? (~w_raw + VALUE_WIDTH'(1)) : w_raw;

    itda_bcd #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_bcd (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_mag       (w_mag),
        .o_done      (w_done),
        .o_top_digit (w_top)
    );

    always_comb begin
        n_state            = r_state;
        n_left             = r_left;
        n_neg              = r_neg;
        w_cmd              = '0;
        i_value_ch.ready   = 1'b0;
        o_char_ch.valid    = 1'b0;
        o_char_ch.char_code = C_ASCII_ZERO + {4'd0, w_top};
        o_char_ch.last     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // no transaction is taken while reset is held
                i_value_ch.ready = i_rst_n;
                if (i_value_ch.valid && i_rst_n) begin
                    w_cmd.start = 1'b1;
                    n_neg       = w_raw[VALUE_WIDTH-1];
                    n_state     = S_CONV;
                end
            end
            S_CONV: begin
                if (w_done) begin
                    n_left  = LEFT_W'(DIGIT_COUNT);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros but always keep the units digit
                if (w_top == 4'd0 && r_left != LEFT_W'(1)) begin
                    w_cmd.shift = 1'b1;
                    n_left      = r_left - LEFT_W'(1);
                end else begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                o_char_ch.valid     = 1'b1;
                o_char_ch.char_code = C_ASCII_MINUS;
                if (o_char_ch.ready) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_char_ch.valid = 1'b1;
                o_char_ch.last  = (r_left == LEFT_W'(1));
                if (o_char_ch.ready) begin
                    w_cmd.shift = 1'b1;
                    n_left      = r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        r_neg  <= n_neg;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/itda_bcd.sv */
// ----------------------------------------------------------------------------
// itda_bcd
// bit-serial binary to bcd conversion (double dabble), one bit per cycle,
// then a digit-wide left shift that hands out the most significant digit
// ----------------------------------------------------------------------------
module itda_bcd #(
    parameter int VALUE_WIDTH = itda_pkg::C_VALUE_WIDTH,
    parameter int DIGIT_COUNT = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  itda_pkg::t_bcd_cmd        i_cmd,
    input  logic [VALUE_WIDTH-1:0]    i_mag,
    output logic                      o_done,
    output logic [3:0]                o_top_digit
);
    import itda_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int BCD_W = DIGIT_COUNT * 4;

    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic [BCD_W-1:0]       w_adj;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_busy, n_busy;
    logic                   r_done, n_done;

    // add-3 correction on every digit, lanes are independent
    always_comb begin
        logic [3:0] d;
        for (int g = 0; g < DIGIT_COUNT; g++) begin
            d = r_bcd[4*g +: 4];
            w_adj[4*g +: 4] = (d >= C_BCD_ADJ_MIN) ? d + C_BCD_ADJ_ADD : d;
        end
    end

    always_comb begin
        n_mag  = r_mag;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_cmd.start) begin
            n_mag  = i_mag;
            n_bcd  = '0;
            n_cnt  = CNT_W'(VALUE_WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {w_adj[BCD_W-2:0], r_mag[VALUE_WIDTH-1]};
            n_mag = {r_mag[VALUE_WIDTH-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_cmd.shift) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done      = r_done;
    assign o_top_digit = r_bcd[BCD_W-1 -: 4];

endmodule
